FILE: src/fdvs_pkg.sv
package fdvs_pkg;

  localparam int unsigned MaxValuesDef = 256;
  localparam int unsigned DomainSizeW  = 9;
  localparam int unsigned ValueW       = 8;
  localparam int unsigned CountW       = 9;
  localparam int unsigned OutDataW     = 40;

  localparam logic [31:0] NoLink32 = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OpInit   = 2'd0,
    OpRemove = 2'd1,
    OpAdd    = 2'd2,
    OpInst   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EvNone         = 2'd0,
    EvRemoval      = 2'd1,
    EvInstantiated = 2'd2,
    EvEmpty        = 2'd3
  } ev_e;

endpackage

FILE: src/fdvs_ram.sv
module fdvs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/finite_domain_value_store.sv
// Domain store for one finite-domain variable over values 0..MaxValues-1. Each input beat carries
// an operation in tuser (init, remove, add above the maximum, instantiate) and a value in tdata;
// each beat gives exactly one output beat with the event and the lowest, highest, count and
// fixed value after the operation. Remove, add and instantiate read the one-read one-write link
// memory in the states StRd0 to StRd3, evaluate in StExec and, when the link memory is updated,
// write up to three link slots in StWr. Outside init, a value of MaxValues or more skips the
// link memory. Init rewrites every link slot, one per cycle; after reset the same clearing pass
// runs before the first input beat is taken, while configuration writes are taken as usual.
module finite_domain_value_store #(
  parameter int unsigned MaxValues = fdvs_pkg::MaxValuesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fdvs_pkg::DomainSizeW-1:0]    cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fdvs_pkg::ValueW-1:0]         s_axis_tdata,  // value
  input  logic [1:0]                          s_axis_tuser,  // op
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_res, lowest, highest, count, is_fixed, fixed_value, zero fill
  output logic [fdvs_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned SlotCount = MaxValues + 1;
  localparam int unsigned AddrW     = $clog2(SlotCount);
  localparam int unsigned LinkW     = $clog2(MaxValues) + 2;
  localparam logic [LinkW-1:0] NoCode     = {1'b0, {(LinkW-1){1'b1}}};
  localparam logic [31:0]      SlotCnt32  = 32'(SlotCount);
  localparam logic [31:0]      MaxVal32   = 32'(MaxValues);
  localparam logic [AddrW-1:0] LastSlot   = AddrW'(SlotCount - 1);

  typedef enum logic [3:0] {
    StIdle, StInit, StRd0, StRd1, StRd2, StRd3, StExec, StWr, StDone
  } st_e;

  function automatic logic [31:0] dec(input logic [LinkW-1:0] x);
    dec = (x == NoCode) ? fdvs_pkg::NoLink32 : {{(32-LinkW){x[LinkW-1]}}, x};
  endfunction

  function automatic logic [LinkW-1:0] enc(input logic [31:0] x);
    enc = (x == fdvs_pkg::NoLink32) ? NoCode : x[LinkW-1:0];
  endfunction

  st_e                            state_q, state_d;
  fdvs_pkg::op_e                  op_q, op_d;
  fdvs_pkg::ev_e                  ev_q, ev_d;
  logic [fdvs_pkg::ValueW-1:0]    val_q, val_d;
  logic                           emit_q, emit_d;
  logic [AddrW-1:0]               sweep_q, sweep_d;
  logic [AddrW-1:0]               n_q, n_d;
  logic [fdvs_pkg::DomainSizeW-1:0] ds_q, ds_d;
  logic [LinkW-1:0]               low_q, low_d, high_q, high_d;
  logic [fdvs_pkg::CountW-1:0]    cnt_q, cnt_d;
  logic [fdvs_pkg::ValueW-1:0]    asg_q, asg_d;
  logic                           asg_v_q, asg_v_d;
  logic [LinkW-1:0]               li_q, li_d, lb_q, lb_d, nx_q, nx_d;
  logic                           wen_q [3];
  logic                           wen_d [3];
  logic [AddrW-1:0]               waddr_q [3];
  logic [AddrW-1:0]               waddr_d [3];
  logic [LinkW-1:0]               wdat_q [3];
  logic [LinkW-1:0]               wdat_d [3];
  logic [1:0]                     widx_q, widx_d;
  logic                           out_v_q, out_v_d;
  logic [fdvs_pkg::OutDataW-1:0]  out_data_q, out_data_d;

  logic                           ram_we;
  logic [AddrW-1:0]               ram_waddr, ram_raddr;
  logic [LinkW-1:0]               ram_wdata, ram_rdata;

  logic [31:0] i32, li32, lb32, nx32, lo32, hi32, prev32, newlo32, newhi32, ds32, n32;
  logic [AddrW-1:0] i_addr;
  logic             fin;

  fdvs_ram #(
    .Width (LinkW),
    .Depth (SlotCount)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign i32    = 32'(val_q);
  assign i_addr = AddrW'(val_q);
  assign li32   = dec(li_q);
  assign lb32   = dec(lb_q);
  assign nx32   = dec(nx_q);
  assign lo32   = dec(low_q);
  assign hi32   = dec(high_q);
  assign prev32 = (lb32 == i32) ? i32 - 32'd2 : lb32;
  assign ds32   = 32'(ds_q);
  assign n32    = (ds32 == 32'd0) ? 32'd1 : ((ds32 > MaxVal32) ? MaxVal32 : ds32);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // link memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = (sweep_q < n_q) ? LinkW'(sweep_q) : NoCode;
    ram_raddr = i_addr;
    case (state_q)
      StInit: begin
        ram_we = 1'b1;
      end
      StWr: begin
        ram_we    = wen_q[widx_q];
        ram_waddr = waddr_q[widx_q];
        ram_wdata = wdat_q[widx_q];
      end
      StRd1: begin
        ram_raddr = AddrW'(i_addr - AddrW'(1));
      end
      StRd2: begin
        ram_raddr = AddrW'(i_addr + AddrW'(1));
      end
      default: begin
        ram_raddr = i_addr;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ev_d       = ev_q;
    val_d      = val_q;
    emit_d     = emit_q;
    sweep_d    = sweep_q;
    n_d        = n_q;
    ds_d       = cfg_we_i ? cfg_wdata_i : ds_q;
    low_d      = low_q;
    high_d     = high_q;
    cnt_d      = cnt_q;
    asg_d      = asg_q;
    asg_v_d    = asg_v_q;
    li_d       = li_q;
    lb_d       = lb_q;
    nx_d       = nx_q;
    widx_d     = widx_q;
    out_v_d    = out_v_q && !m_axis_tready;
    out_data_d = out_data_q;
    newlo32    = lo32;
    newhi32    = hi32;
    fin        = 1'b0;
    for (int k = 0; k < 3; k++) begin
      wen_d[k]   = wen_q[k];
      waddr_d[k] = waddr_q[k];
      wdat_d[k]  = wdat_q[k];
    end

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          op_d  = fdvs_pkg::op_e'(s_axis_tuser);
          val_d = s_axis_tdata;
          if (fdvs_pkg::op_e'(s_axis_tuser) == fdvs_pkg::OpInit) begin
            n_d     = AddrW'(n32);
            sweep_d = '0;
            emit_d  = 1'b1;
            state_d = StInit;
          end else if (32'(s_axis_tdata) >= MaxVal32) begin
            ev_d    = fdvs_pkg::EvNone;
            state_d = StDone;
          end else begin
            state_d = StRd0;
          end
        end
      end
      StInit: begin
        sweep_d = AddrW'(sweep_q + AddrW'(1));
        if (sweep_q == LastSlot) begin
          low_d   = '0;
          high_d  = LinkW'(LinkW'(n_q) - LinkW'(1));
          cnt_d   = fdvs_pkg::CountW'(n_q);
          asg_d   = '0;
          asg_v_d = (n_q == AddrW'(1));
          ev_d    = fdvs_pkg::EvNone;
          state_d = emit_q ? StDone : StIdle;
        end
      end
      StRd0: begin
        state_d = StRd1;
      end
      StRd1: begin
        li_d    = ram_rdata;
        state_d = StRd2;
      end
      StRd2: begin
        lb_d    = (val_q == '0) ? NoCode : ram_rdata;
        state_d = StRd3;
      end
      StRd3: begin
        nx_d    = ram_rdata;
        state_d = StExec;
      end
      StExec: begin
        for (int k = 0; k < 3; k++) begin
          wen_d[k] = 1'b0;
        end
        ev_d = fdvs_pkg::EvNone;
        case (op_q)
          fdvs_pkg::OpRemove: begin
            if (li32 != i32) begin
              ev_d = fdvs_pkg::EvNone;
            end else if (lo32 == hi32) begin
              ev_d = fdvs_pkg::EvEmpty;
            end else begin
              cnt_d = cnt_q - fdvs_pkg::CountW'(1);
              if (i32 == lo32) begin
                low_d      = enc(nx32);
                newlo32    = nx32;
                wen_d[0]   = 1'b1;
                waddr_d[0] = i_addr;
                wdat_d[0]  = NoCode;
                fin        = 1'b1;
              end else if (i32 == hi32) begin
                high_d     = enc(prev32);
                newhi32    = prev32;
                wen_d[0]   = 1'b1;
                waddr_d[0] = i_addr;
                wdat_d[0]  = NoCode;
                fin        = 1'b1;
              end else begin
                wen_d[0]   = (prev32 != i32 - 32'd1);
                waddr_d[0] = i_addr;
                wdat_d[0]  = NoCode;
                wen_d[1]   = (prev32 + 32'd2 != nx32) && (nx32 - 32'd1 < SlotCnt32);
                waddr_d[1] = AddrW'(nx32 - 32'd1);
                wdat_d[1]  = enc(prev32);
                wen_d[2]   = (prev32 + 32'd1 < SlotCnt32);
                waddr_d[2] = AddrW'(prev32 + 32'd1);
                wdat_d[2]  = enc(nx32);
                ev_d       = fdvs_pkg::EvRemoval;
              end
              if (fin) begin
                if (newlo32 == newhi32) begin
                  asg_d   = newlo32[fdvs_pkg::ValueW-1:0];
                  asg_v_d = 1'b1;
                  ev_d    = fdvs_pkg::EvInstantiated;
                end else begin
                  ev_d = fdvs_pkg::EvRemoval;
                end
              end
            end
          end
          fdvs_pkg::OpAdd: begin
            if (i32 > hi32) begin
              wen_d[0]   = 1'b1;
              waddr_d[0] = i_addr;
              wdat_d[0]  = enc(i32);
              high_d     = enc(i32);
              cnt_d      = cnt_q + fdvs_pkg::CountW'(1);
              if (hi32 < i32 - 32'd1) begin
                wen_d[1]   = (hi32 != i32 - 32'd2);
                waddr_d[1] = AddrW'(i32 - 32'd1);
                wdat_d[1]  = enc(hi32);
                wen_d[2]   = (hi32 + 32'd1 < SlotCnt32);
                waddr_d[2] = AddrW'(hi32 + 32'd1);
                wdat_d[2]  = enc(i32);
              end
              asg_v_d = 1'b0;
              asg_d   = '0;
            end
          end
          fdvs_pkg::OpInst: begin
            if (li32 != i32) begin
              ev_d = fdvs_pkg::EvEmpty;
            end else if (!asg_v_q) begin
              asg_d   = val_q;
              asg_v_d = 1'b1;
              low_d   = enc(i32);
              high_d  = enc(i32);
              cnt_d   = fdvs_pkg::CountW'(1);
              ev_d    = fdvs_pkg::EvInstantiated;
            end
          end
          default: begin
            ev_d = fdvs_pkg::EvNone;
          end
        endcase
        widx_d  = '0;
        state_d = (wen_d[0] || wen_d[1] || wen_d[2]) ? StWr : StDone;
      end
      StWr: begin
        widx_d = widx_q + 2'd1;
        if (widx_q == 2'd2) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d    = 1'b1;
          out_data_d = {4'b0,
                        (asg_v_q ? asg_q : {fdvs_pkg::ValueW{1'b0}}),
                        asg_v_q,
                        cnt_q,
                        hi32[7:0],
                        lo32[7:0],
                        ev_q};
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      op_q    <= fdvs_pkg::OpInit;
      ev_q    <= fdvs_pkg::EvNone;
      emit_q  <= 1'b0;
      sweep_q <= '0;
      n_q     <= AddrW'(1);
      ds_q    <= fdvs_pkg::DomainSizeW'(1);
      low_q   <= '0;
      high_q  <= '0;
      cnt_q   <= fdvs_pkg::CountW'(1);
      asg_q   <= '0;
      asg_v_q <= 1'b0;
      widx_q  <= '0;
      out_v_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        wen_q[k] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ev_q    <= ev_d;
      emit_q  <= emit_d;
      sweep_q <= sweep_d;
      n_q     <= n_d;
      ds_q    <= ds_d;
      low_q   <= low_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
      asg_q   <= asg_d;
      asg_v_q <= asg_v_d;
      widx_q  <= widx_d;
      out_v_q <= out_v_d;
      for (int k = 0; k < 3; k++) begin
        wen_q[k] <= wen_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    li_q       <= li_d;
    lb_q       <= lb_d;
    nx_q       <= nx_d;
    out_data_q <= out_data_d;
    for (int k = 0; k < 3; k++) begin
      waddr_q[k] <= waddr_d[k];
      wdat_q[k]  <= wdat_d[k];
    end
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !ram_we)
    else $error("link memory written while idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != StIdle))
    else $error("accepted beat not processed");

  a_unassigned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !asg_v_q |-> (asg_q == '0))
    else $error("fixed value held without assignment");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInit) |-> (sweep_q <= LastSlot))
    else $error("clearing pass beyond last slot");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == StDone))
    else $error("output beat loaded outside done state");
`endif

endmodule

FILE: test/finite_domain_value_store_tb.sv
`timescale 1ns / 1ps

module finite_domain_value_store_tb;
  import fdvs_pkg::*;

  localparam int unsigned SlotCount  = MaxValuesDef + 1;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumRows    = 28;

  typedef struct packed {
    ev_e                ev;
    logic [ValueW-1:0]  lowest;
    logic [ValueW-1:0]  highest;
    logic [CountW-1:0]  count;
    logic               fixed;
    logic [ValueW-1:0]  fixed_val;
  } dom_report_t;

  typedef struct {
    bit                     cfg;
    logic [DomainSizeW-1:0] size;
    op_e                    op;
    logic [ValueW-1:0]      val;
    bit                     typed;
    dom_report_t            want;
  } step_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [DomainSizeW-1:0] cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [ValueW-1:0]      s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OpInit;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataW-1:0]    m_axis_tdata;

  finite_domain_value_store i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // domain state mirrored at full word width
  logic [31:0]            dom_links [SlotCount];
  logic [31:0]            dom_lo;
  logic [31:0]            dom_hi;
  logic [31:0]            dom_count;
  logic [31:0]            dom_fixed;
  bit                     dom_fixed_ok;
  logic [DomainSizeW-1:0] dom_size;

  dom_report_t pending_reports [$];
  step_row_t   dir_rows [NumRows];

  int unsigned src_idle_pct = 36;
  int unsigned snk_idle_pct = 53;
  int unsigned mismatches   = 0;
  int unsigned op_seen [4]  = '{0, 0, 0, 0};
  int unsigned ev_seen [4]  = '{0, 0, 0, 0};

  function automatic logic [31:0] rd_link(logic [31:0] slot);
    return (slot < SlotCount) ? dom_links[slot] : NoLink32;
  endfunction

  function automatic void wr_link(logic [31:0] slot, logic [31:0] v);
    if (slot < SlotCount) dom_links[slot] = v;
  endfunction

  function automatic void dom_reinit();
    int unsigned n;
    n = dom_size;
    if (n < 1) n = 1;
    if (n > MaxValuesDef) n = MaxValuesDef;
    for (int unsigned k = 0; k < SlotCount; k++) dom_links[k] = (k < n) ? k : NoLink32;
    dom_lo       = 0;
    dom_hi       = n - 1;
    dom_count    = n;
    dom_fixed    = 0;
    dom_fixed_ok = (n == 1);
  endfunction

  function automatic ev_e dom_remove(logic [31:0] i);
    logic [31:0] below, prev, next;
    if (rd_link(i) != i) return EvNone;
    if (dom_lo == dom_hi) return EvEmpty;
    dom_count = dom_count - 1;
    if (i == dom_lo) begin
      dom_lo = rd_link(i + 1);
      wr_link(i, NoLink32);
    end else begin
      below = rd_link(i - 1);
      prev  = (below == i) ? i - 2 : below;
      if (i == dom_hi) begin
        dom_hi = prev;
        wr_link(i, NoLink32);
      end else begin
        // interior value: join the removed runs on both sides
        next = rd_link(i + 1);
        if (prev != i - 1) wr_link(i, NoLink32);
        if (prev + 2 != next) wr_link(next - 1, prev);
        wr_link(prev + 1, next);
        return EvRemoval;
      end
    end
    if (dom_lo == dom_hi) begin
      dom_fixed    = dom_lo;
      dom_fixed_ok = 1'b1;
      return EvInstantiated;
    end
    return EvRemoval;
  endfunction

  function automatic void dom_add(logic [31:0] i);
    logic [31:0] old;
    old = dom_hi;
    if (i > old) begin
      wr_link(i, i);
      dom_hi    = i;
      dom_count = dom_count + 1;
      if (old < i - 1) begin
        if (old != i - 2) wr_link(i - 1, old);
        wr_link(old + 1, i);
      end
      dom_fixed_ok = 1'b0;
      dom_fixed    = 0;
    end
  endfunction

  function automatic ev_e dom_instantiate(logic [31:0] i);
    if (rd_link(i) != i) return EvEmpty;
    if (dom_fixed_ok) return EvNone;
    dom_fixed    = i;
    dom_fixed_ok = 1'b1;
    dom_lo       = i;
    dom_hi       = i;
    dom_count    = 1;
    return EvInstantiated;
  endfunction

  function automatic dom_report_t dom_apply(op_e op, logic [ValueW-1:0] val);
    dom_report_t r;
    ev_e         ev;
    logic [31:0] i;
    ev = EvNone;
    i  = {{(32 - ValueW){1'b0}}, val};
    case (op)
      OpInit:   dom_reinit();
      OpRemove: ev = dom_remove(i);
      OpAdd:    dom_add(i);
      default:  ev = dom_instantiate(i);
    endcase
    r.ev        = ev;
    r.lowest    = dom_lo[ValueW-1:0];
    r.highest   = dom_hi[ValueW-1:0];
    r.count     = dom_count[CountW-1:0];
    r.fixed     = dom_fixed_ok;
    r.fixed_val = dom_fixed_ok ? dom_fixed[ValueW-1:0] : '0;
    return r;
  endfunction

  function automatic dom_report_t rep(ev_e e, int lo, int hi, int n, bit f, int fv);
    dom_report_t r;
    r.ev        = e;
    r.lowest    = lo[ValueW-1:0];
    r.highest   = hi[ValueW-1:0];
    r.count     = n[CountW-1:0];
    r.fixed     = f;
    r.fixed_val = fv[ValueW-1:0];
    return r;
  endfunction

  function automatic bit same_report(dom_report_t a, dom_report_t b);
    return a.ev === b.ev && a.lowest === b.lowest && a.highest === b.highest &&
           a.count === b.count && a.fixed === b.fixed && a.fixed_val === b.fixed_val;
  endfunction

  task automatic push_item(input op_e op, input logic [ValueW-1:0] val, input bit typed,
                           input dom_report_t want);
    dom_report_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = dom_apply(op, val);
    pending_reports.push_back(typed ? want : predicted);
    op_seen[int'(op)]++;
  endtask

  task automatic drain_and_set_size(input logic [DomainSizeW-1:0] sz);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dom_size = sz;
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    dom_report_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ev        = ev_e'(m_axis_tdata[1:0]);
      got.lowest    = m_axis_tdata[9:2];
      got.highest   = m_axis_tdata[17:10];
      got.count     = m_axis_tdata[26:18];
      got.fixed     = m_axis_tdata[27];
      got.fixed_val = m_axis_tdata[35:28];
      ev_seen[int'(got.ev)]++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing pending: ev=%0d lo=%0d hi=%0d n=%0d fix=%0b/%0d",
                   $realtime, got.ev, got.lowest, got.highest, got.count, got.fixed,
                   got.fixed_val);
      end else begin
        exp_r = pending_reports.pop_front();
        if (!same_report(exp_r, got)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch expected ev=%0d lo=%0d hi=%0d n=%0d fix=%0b/%0d", $realtime,
                     exp_r.ev, exp_r.lowest, exp_r.highest, exp_r.count, exp_r.fixed,
                     exp_r.fixed_val);
            $display("%0t:          actual   ev=%0d lo=%0d hi=%0d n=%0d fix=%0b/%0d", $realtime,
                     got.ev, got.lowest, got.highest, got.count, got.fixed, got.fixed_val);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding", StallLimit,
             pending_reports.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned            budget, len, roll, sel, span;
    op_e                    op;
    logic [ValueW-1:0]      v, inb;
    logic [DomainSizeW-1:0] sz;

    dom_size = 1;
    dom_reinit();

    dir_rows[0]  = '{1'b0, 9'd0,   OpRemove, 8'd0,   1'b1, rep(EvEmpty, 0, 0, 1, 1, 0)};
    dir_rows[1]  = '{1'b0, 9'd0,   OpInst,   8'd0,   1'b1, rep(EvNone, 0, 0, 1, 1, 0)};
    dir_rows[2]  = '{1'b0, 9'd0,   OpAdd,    8'd255, 1'b1, rep(EvNone, 0, 255, 2, 0, 0)};
    dir_rows[3]  = '{1'b0, 9'd0,   OpRemove, 8'd255, 1'b1,
                     rep(EvInstantiated, 0, 0, 1, 1, 0)};
    dir_rows[4]  = '{1'b1, 9'd256, OpInit,   8'd0,   1'b0, '0};
    dir_rows[5]  = '{1'b0, 9'd0,   OpInit,   8'd0,   1'b1, rep(EvNone, 0, 255, 256, 0, 0)};
    dir_rows[6]  = '{1'b0, 9'd0,   OpRemove, 8'd0,   1'b1, rep(EvRemoval, 1, 255, 255, 0, 0)};
    dir_rows[7]  = '{1'b0, 9'd0,   OpRemove, 8'd255, 1'b0, '0};
    dir_rows[8]  = '{1'b0, 9'd0,   OpRemove, 8'd100, 1'b0, '0};
    dir_rows[9]  = '{1'b0, 9'd0,   OpRemove, 8'd101, 1'b0, '0};
    dir_rows[10] = '{1'b0, 9'd0,   OpRemove, 8'd99,  1'b0, '0};
    dir_rows[11] = '{1'b0, 9'd0,   OpRemove, 8'd100, 1'b0, '0};
    dir_rows[12] = '{1'b0, 9'd0,   OpAdd,    8'd10,  1'b0, '0};
    dir_rows[13] = '{1'b0, 9'd0,   OpInst,   8'd100, 1'b0, '0};
    dir_rows[14] = '{1'b0, 9'd0,   OpInst,   8'd50,  1'b0, '0};
    dir_rows[15] = '{1'b0, 9'd0,   OpInst,   8'd60,  1'b0, '0};
    dir_rows[16] = '{1'b0, 9'd0,   OpAdd,    8'd200, 1'b0, '0};
    dir_rows[17] = '{1'b0, 9'd0,   OpRemove, 8'd200, 1'b0, '0};
    dir_rows[18] = '{1'b1, 9'd0,   OpInit,   8'd0,   1'b0, '0};
    dir_rows[19] = '{1'b0, 9'd0,   OpInit,   8'd77,  1'b1, rep(EvNone, 0, 0, 1, 1, 0)};
    dir_rows[20] = '{1'b0, 9'd0,   OpRemove, 8'd0,   1'b1, rep(EvEmpty, 0, 0, 1, 1, 0)};
    dir_rows[21] = '{1'b1, 9'd2,   OpInit,   8'd0,   1'b0, '0};
    dir_rows[22] = '{1'b0, 9'd0,   OpInit,   8'd0,   1'b1, rep(EvNone, 0, 1, 2, 0, 0)};
    dir_rows[23] = '{1'b0, 9'd0,   OpRemove, 8'd1,   1'b1,
                     rep(EvInstantiated, 0, 0, 1, 1, 0)};
    dir_rows[24] = '{1'b1, 9'd511, OpInit,   8'd0,   1'b0, '0};
    dir_rows[25] = '{1'b0, 9'd0,   OpInit,   8'd255, 1'b1, rep(EvNone, 0, 255, 256, 0, 0)};
    dir_rows[26] = '{1'b0, 9'd0,   OpAdd,    8'd255, 1'b1, rep(EvNone, 0, 255, 256, 0, 0)};
    dir_rows[27] = '{1'b0, 9'd0,   OpInst,   8'd255, 1'b1,
                     rep(EvInstantiated, 255, 255, 1, 1, 255)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg) drain_and_set_size(dir_rows[r].size);
      else push_item(dir_rows[r].op, dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 53 : 0;
      snk_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 36 : 0;
      budget = 235;
      while (budget > 0) begin
        // mostly a fresh domain, sometimes carry on from whatever state is left
        if ($urandom_range(99) < 85) begin
          sel = $urandom_range(99);
          if (sel < 60) sz = $urandom_range(1, 16);
          else if (sel < 85) sz = $urandom_range(17, 64);
          else if (sel < 95) sz = MaxValuesDef;
          else sz = $urandom_range(0, 511);
          drain_and_set_size(sz);
          push_item(OpInit, $urandom, 1'b0, '0);
          budget = (budget > 0) ? budget - 1 : 0;
        end
        len = $urandom_range(12, 40);
        for (int unsigned k = 0; k < len && budget > 0; k++) begin
          roll = $urandom_range(99);
          if (dom_hi >= dom_lo && dom_hi < MaxValuesDef) begin
            span = dom_hi - dom_lo;
            inb  = dom_lo[ValueW-1:0] + ValueW'($urandom_range(0, span));
          end else begin
            inb = $urandom;
          end
          if (roll < 55) begin
            op = OpRemove;
            v  = inb;
          end else if (roll < 70) begin
            op = OpAdd;
            v  = (dom_hi < 252) ? dom_hi[ValueW-1:0] + ValueW'($urandom_range(1, 3)) : $urandom;
          end else if (roll < 80) begin
            op = OpInst;
            v  = inb;
          end else begin
            op = ($urandom_range(19) == 0) ? OpInit : op_e'($urandom_range(1, 3));
            v  = $urandom;
          end
          push_item(op, v, 1'b0, '0);
          budget--;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("covered %0d input beats: init %0d, remove %0d, add %0d, instantiate %0d",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[0], op_seen[1],
             op_seen[2], op_seen[3]);
    $display("events returned: none %0d, removal %0d, instantiated %0d, empty %0d; %0d bad",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
